// ----- rtl/tvsr_pkg.sv -----
// Shared types and constants for the TLB victim select and refill block.
// Used by every module of the block; depends on nothing.
package tvsr_pkg;

    localparam int TICK_BITS  = 32;
    localparam int ADDR_BITS  = 32;
    localparam int PAGE_BITS  = 25;
    localparam int FRAME_BITS = 8;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_REFILL = 1'b1;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_NFU = 1'b1;

    localparam logic [TICK_BITS-1:0] REF_LIMIT = 32'd999_999_998;

    localparam int NUM_DIV      = 4;
    localparam int DIVISOR_BITS = 7;
    localparam int DIV_SHIFT    = 39;
    localparam int RECIP_BITS   = 34;
    localparam int QUO_BITS     = 26;

    function automatic logic [DIVISOR_BITS-1:0] tick_divisor(input logic [1:0] sel);
        logic [DIVISOR_BITS-1:0] d;
        case (sel)
            2'd0:    d = 7'd100;
            2'd1:    d = 7'd101;
            2'd2:    d = 7'd102;
            default: d = 7'd103;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/tvsr_tick_div.sv -----
// Divisibility test of the tick by 100, 101, 102 and 103 for the NFU override.
// A reciprocal multiply forms each quotient into a register; the held tick is then checked
// against quotient times divisor. Depends on tvsr_pkg.
module tvsr_tick_div (
    input  logic                           clk,
    input  logic                           load,
    input  logic [tvsr_pkg::TICK_BITS-1:0] tick_in,
    input  logic [tvsr_pkg::TICK_BITS-1:0] tick_held,
    output logic [tvsr_pkg::NUM_DIV-1:0]   divisible
);
    import tvsr_pkg::*;

    for (genvar g = 0; g < NUM_DIV; g++) begin : g_div
        localparam logic [DIVISOR_BITS-1:0] D = tick_divisor(2'(g));
        localparam logic [RECIP_BITS-1:0] RECIP =
            RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'(D) - 64'd1) / 64'(D));

        logic [TICK_BITS+RECIP_BITS-1:0] prod;
        logic [QUO_BITS-1:0]             quo_reg;
        logic [TICK_BITS:0]              back;

        assign prod = (TICK_BITS+RECIP_BITS)'(tick_in) * (TICK_BITS+RECIP_BITS)'(RECIP);

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                quo_reg <= prod[DIV_SHIFT +: QUO_BITS];
            end
        end

        assign back         = (TICK_BITS+1)'(quo_reg) * (TICK_BITS+1)'(D);
        assign divisible[g] = (back == {1'b0, tick_held});
    end

endmodule

// ----- rtl/tvsr_victim_pick.sv -----
// Victim choice among the entries: the first invalid entry, or else the entry with the
// smallest key, lowest index on a tie. Depends on tvsr_pkg.
module tvsr_victim_pick #(
    parameter int ENTRIES = 4
) (
    input  logic [ENTRIES-1:0]             valid,
    input  logic [tvsr_pkg::TICK_BITS-1:0] key [ENTRIES],
    output logic [$clog2(ENTRIES)-1:0]     pick
);
    import tvsr_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic             any_free;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] min_idx;
    logic [ENTRIES-1:0] is_min;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            is_min[i] = 1'b1;
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (j < i && !(key[i] < key[j]))
                begin
                    is_min[i] = 1'b0;
                end
                if (j > i && key[j] < key[i])
                begin
                    is_min[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        min_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (is_min[i])
            begin
                min_idx = IDX_W'(i);
            end
        end
    end

    assign pick = any_free ? free_idx : min_idx;

endmodule

// ----- rtl/tlb_victim_select_and_refill.sv -----
// Top level of the software-refilled TLB with LRU or NFU victim choice.
// Depends on tvsr_pkg, tvsr_tick_div and tvsr_victim_pick.
//
// The input channel (in_valid, in_stall) carries one word per access: a lookup or a refill
// with its tick, address, write flag and page-table fields. The output channel
// (out_valid, out_stall) returns exactly one result word per input word, in order.
// The configuration channel (cfg_valid, cfg_ready) writes the one-bit policy register;
// cfg_ready is always high, and writes are expected only while the block is idle.
// An input word is first captured in an input register, together with the tick quotients
// for the NFU override. When the word leaves the input register, the tag compare, the
// victim choice and the entry update all complete and the result is loaded into the output
// register, which raises out_valid. One word is accepted every cycle while the output is
// not stalled; the rate is set by the single compare-and-update pass over the entry
// registers. A stalled output holds its result; the input register keeps one more word
// and then in_stall rises until the receiver takes the result.
// Reset empties both registers, invalidates and clears every entry and selects NFU.
// PAGE_BYTES must be a power of two; TLB_ENTRIES must be 4, as victim_index is two bits wide.
module tlb_victim_select_and_refill #(
    parameter int TLB_ENTRIES = 4,
    parameter int PAGE_BYTES  = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            operation,
    input  logic [tvsr_pkg::TICK_BITS-1:0]  tick,
    input  logic [tvsr_pkg::ADDR_BITS-1:0]  virtual_address,
    input  logic                            is_write,
    input  logic                            table_valid,
    input  logic [tvsr_pkg::FRAME_BITS-1:0] table_frame,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [tvsr_pkg::FRAME_BITS-1:0] frame_out,
    output logic [1:0]                      victim_index,
    output logic                            evicted_valid,
    output logic [tvsr_pkg::PAGE_BITS-1:0]  evicted_page,
    output logic                            evicted_dirty,
    output logic                            page_fault
);
    import tvsr_pkg::*;

    localparam int IDX_W      = $clog2(TLB_ENTRIES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    logic policy_reg;

    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic [TICK_BITS-1:0]  s1_tick_reg;
    logic [PAGE_BITS-1:0]  s1_page_reg;
    logic                  s1_write_reg;
    logic                  s1_tvalid_reg;
    logic [FRAME_BITS-1:0] s1_tframe_reg;

    logic [TLB_ENTRIES-1:0] entry_valid_reg;
    logic [PAGE_BITS-1:0]   entry_page_reg  [TLB_ENTRIES];
    logic [FRAME_BITS-1:0]  entry_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] entry_dirty_reg;
    logic [TICK_BITS-1:0]   entry_last_reg  [TLB_ENTRIES];
    logic [TICK_BITS-1:0]   entry_ref_reg   [TLB_ENTRIES];

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [1:0]            victim_reg;
    logic                  ev_valid_reg;
    logic [PAGE_BITS-1:0]  ev_page_reg;
    logic                  ev_dirty_reg;
    logic                  fault_reg;

    logic                  hit_next;
    logic [FRAME_BITS-1:0] frame_next;
    logic [1:0]            victim_next;
    logic                  ev_valid_next;
    logic [PAGE_BITS-1:0]  ev_page_next;
    logic                  ev_dirty_next;
    logic                  fault_next;

    logic                 in_accept;
    logic                 s1_advance;
    logic [PAGE_BITS-1:0] page_in;
    logic [NUM_DIV-1:0]   tick_div;
    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     pick_idx;
    logic [IDX_W-1:0]     victim_idx;
    logic [TICK_BITS-1:0] pick_key [TLB_ENTRIES];
    logic [TICK_BITS-1:0] ref_inc;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;
    assign page_in    = PAGE_BITS'(virtual_address >> PAGE_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_NFU;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg     <= operation;
            s1_tick_reg   <= tick;
            s1_page_reg   <= page_in;
            s1_write_reg  <= is_write;
            s1_tvalid_reg <= table_valid;
            s1_tframe_reg <= table_frame;
        end
    end

    tvsr_tick_div u_tick_div (
        .clk       (clk),
        .load      (in_accept),
        .tick_in   (tick),
        .tick_held (s1_tick_reg),
        .divisible (tick_div)
    );

    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (entry_valid_reg[i] && entry_page_reg[i] == s1_page_reg)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            pick_key[i] = (policy_reg == POLICY_NFU) ? entry_ref_reg[i] : entry_last_reg[i];
        end
    end

    tvsr_victim_pick #(
        .ENTRIES (TLB_ENTRIES)
    ) u_victim_pick (
        .valid (entry_valid_reg),
        .key   (pick_key),
        .pick  (pick_idx)
    );

    always_comb
    begin
        victim_idx = pick_idx;
        if (policy_reg == POLICY_NFU)
        begin
            for (int k = NUM_DIV - 1; k >= 0; k--)
            begin
                if (tick_div[k])
                begin
                    victim_idx = IDX_W'(k);
                end
            end
        end
    end

    assign ref_inc = (entry_ref_reg[hit_idx] < REF_LIMIT) ?
                     entry_ref_reg[hit_idx] + 32'd1 : REF_LIMIT;

    always_comb
    begin
        hit_next      = 1'b0;
        frame_next    = '0;
        victim_next   = '0;
        ev_valid_next = 1'b0;
        ev_page_next  = '0;
        ev_dirty_next = 1'b0;
        fault_next    = 1'b0;
        if (s1_op_reg == OP_LOOKUP)
        begin
            hit_next = hit_any;
            if (hit_any)
            begin
                frame_next = entry_frame_reg[hit_idx];
            end
        end
        else
        begin
            frame_next    = s1_tframe_reg;
            victim_next   = victim_idx[1:0];
            ev_valid_next = entry_valid_reg[victim_idx];
            if (entry_valid_reg[victim_idx])
            begin
                ev_page_next  = entry_page_reg[victim_idx];
                ev_dirty_next = entry_dirty_reg[victim_idx];
            end
            fault_next = !s1_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            entry_dirty_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                entry_page_reg[i]  <= '0;
                entry_frame_reg[i] <= '0;
                entry_last_reg[i]  <= '0;
                entry_ref_reg[i]   <= '0;
            end
        end
        else if (s1_advance)
        begin
            if (s1_op_reg == OP_LOOKUP)
            begin
                if (hit_any)
                begin
                    entry_last_reg[hit_idx]  <= s1_tick_reg;
                    entry_ref_reg[hit_idx]   <= ref_inc;
                    entry_dirty_reg[hit_idx] <= entry_dirty_reg[hit_idx] | s1_write_reg;
                end
            end
            else
            begin
                entry_valid_reg[victim_idx] <= 1'b1;
                entry_page_reg[victim_idx]  <= s1_page_reg;
                entry_frame_reg[victim_idx] <= s1_tframe_reg;
                entry_dirty_reg[victim_idx] <= 1'b0;
                entry_last_reg[victim_idx]  <= s1_tick_reg;
                entry_ref_reg[victim_idx]   <= 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            hit_reg      <= hit_next;
            frame_reg    <= frame_next;
            victim_reg   <= victim_next;
            ev_valid_reg <= ev_valid_next;
            ev_page_reg  <= ev_page_next;
            ev_dirty_reg <= ev_dirty_next;
            fault_reg    <= fault_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_out     = frame_reg;
    assign victim_index  = victim_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign evicted_dirty = ev_dirty_reg;
    assign page_fault    = fault_reg;

    // The input side backs up only when a result is waiting on a stalled receiver.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("in_stall raised without a held word behind a stalled result");

    // A refill leaves its victim valid with a fresh reference count.
    a_refill_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_op_reg == OP_REFILL |=>
            entry_valid_reg[$past(victim_idx)] && entry_ref_reg[$past(victim_idx)] == 32'd1)
        else $error("refilled entry not valid with reference count one");

    for (genvar e = 0; e < TLB_ENTRIES; e++) begin : g_ref_chk
        a_ref_sat: assert property (@(posedge clk) disable iff (!rst_n)
            entry_ref_reg[e] <= REF_LIMIT)
            else $error("reference count above its saturation limit");
    end

endmodule

// ----- tb/tlb_victim_select_and_refill_test.sv -----
// Self-checking testbench for tlb_victim_select_and_refill: predicts each result word from a
// local model of the four TLB entries and the victim policy and checks it field by field.
// Depends on tvsr_pkg and the tlb_victim_select_and_refill RTL only.
module tlb_victim_select_and_refill_test;
    import tvsr_pkg::*;

    localparam int TLB_ENTRIES = 4;
    localparam int PAGE_BYTES = 128;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int NFU_FIRST_DIVISOR = 100;
    localparam int PAGE_POOL = 6;
    localparam int RANDOM_WORDS = 135;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic                  op;
        logic [TICK_BITS-1:0]  tick;
        logic [ADDR_BITS-1:0]  addr;
        logic                  write_access;
        logic                  table_ok;
        logic [FRAME_BITS-1:0] frame;
    } tlb_access_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame;
        logic [1:0]            victim;
        logic                  ev_valid;
        logic [PAGE_BITS-1:0]  ev_page;
        logic                  ev_dirty;
        logic                  fault;
    } tlb_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = 1'b0;
    logic [TICK_BITS-1:0]  tick = '0;
    logic [ADDR_BITS-1:0]  virtual_address = '0;
    logic                  is_write = 1'b0;
    logic                  table_valid = 1'b0;
    logic [FRAME_BITS-1:0] table_frame = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_out;
    logic [1:0]            victim_index;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic                  evicted_dirty;
    logic                  page_fault;

    logic                  policy_now = POLICY_NFU;
    logic                  tlb_valid [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]  tlb_page [TLB_ENTRIES];
    logic [FRAME_BITS-1:0] tlb_frame [TLB_ENTRIES];
    logic                  tlb_dirty [TLB_ENTRIES];
    logic [TICK_BITS-1:0]  tlb_last_use [TLB_ENTRIES];
    logic [TICK_BITS-1:0]  tlb_refs [TLB_ENTRIES];
    logic [TICK_BITS-1:0]  tick_now = '0;

    tlb_outcome_t expected_results [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int lookups = 0;
    int lookup_hits = 0;
    int refills = 0;
    int faults = 0;
    int dirty_evictions = 0;

    tlb_victim_select_and_refill #(
        .TLB_ENTRIES(TLB_ENTRIES),
        .PAGE_BYTES(PAGE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .tick(tick),
        .virtual_address(virtual_address),
        .is_write(is_write),
        .table_valid(table_valid),
        .table_frame(table_frame),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .frame_out(frame_out),
        .victim_index(victim_index),
        .evicted_valid(evicted_valid),
        .evicted_page(evicted_page),
        .evicted_dirty(evicted_dirty),
        .page_fault(page_fault)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic tlb_outcome_t translate_access(tlb_access_t a);
        tlb_outcome_t r;
        logic [PAGE_BITS-1:0] pg;
        int v;
        int best;
        r = '0;
        pg = PAGE_BITS'(a.addr >> PAGE_SHIFT);
        if (a.op == OP_LOOKUP)
        begin
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                if (tlb_valid[i] && tlb_page[i] == pg)
                begin
                    tlb_last_use[i] = a.tick;
                    if (tlb_refs[i] < REF_LIMIT)
                        tlb_refs[i] = tlb_refs[i] + 1;
                    if (a.write_access)
                        tlb_dirty[i] = 1'b1;
                    r.hit = 1'b1;
                    r.frame = tlb_frame[i];
                    return r;
                end
            end
            return r;
        end
        v = -1;
        if (policy_now == POLICY_NFU)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (v < 0 && a.tick % 32'(NFU_FIRST_DIVISOR + k) == 0)
                    v = k;
            end
        end
        if (v < 0)
        begin
            best = 0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                if (v < 0 && !tlb_valid[i])
                    v = i;
                if (policy_now == POLICY_NFU ? tlb_refs[i] < tlb_refs[best]
                                             : tlb_last_use[i] < tlb_last_use[best])
                    best = i;
            end
            if (v < 0)
                v = best;
        end
        r.frame = a.frame;
        r.victim = 2'(v);
        r.ev_valid = tlb_valid[v];
        if (tlb_valid[v])
        begin
            r.ev_page = tlb_page[v];
            r.ev_dirty = tlb_dirty[v];
        end
        r.fault = !a.table_ok;
        tlb_valid[v] = 1'b1;
        tlb_page[v] = pg;
        tlb_frame[v] = a.frame;
        tlb_dirty[v] = 1'b0;
        tlb_last_use[v] = a.tick;
        tlb_refs[v] = 1;
        return r;
    endfunction

    function automatic logic [TICK_BITS-1:0] next_tick();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            tick_now = 32'($urandom_range(1, 42949)) * 32'(NFU_FIRST_DIVISOR + $urandom_range(3));
        else if (pick < 15)
            tick_now = $urandom;
        else
            tick_now = tick_now + $urandom_range(0, 40);
        return tick_now;
    endfunction

    task automatic send_access(input tlb_access_t a, output tlb_outcome_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation <= a.op;
        tick <= a.tick;
        virtual_address <= a.addr;
        is_write <= a.write_access;
        table_valid <= a.table_ok;
        table_frame <= a.frame;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = translate_access(a);
        expected_results.push_back(r);
        if (a.op == OP_LOOKUP)
        begin
            lookups++;
            lookup_hits += r.hit;
        end
        else
        begin
            refills++;
            faults += r.fault;
            dirty_evictions += r.ev_dirty;
        end
    endtask

    task automatic send_fields(logic op, logic [TICK_BITS-1:0] t, logic [ADDR_BITS-1:0] addr,
                               logic wr, logic tv, logic [FRAME_BITS-1:0] tf);
        tlb_access_t a;
        tlb_outcome_t r;
        a.op = op;
        a.tick = t;
        a.addr = addr;
        a.write_access = wr;
        a.table_ok = tv;
        a.frame = tf;
        send_access(a, r);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_policy(logic mode);
        drain_results();
        cfg_data <= mode;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        policy_now = mode;
    endtask

    task automatic run_random_words(int count);
        logic [PAGE_BITS-1:0] pool [PAGE_POOL];
        tlb_access_t a;
        tlb_outcome_t r;
        int sent;
        for (int i = 0; i < PAGE_POOL; i++)
            pool[i] = PAGE_BITS'($urandom);
        pool[0] = '0;
        pool[1] = '1;
        sent = 0;
        while (sent < count)
        begin
            a.tick = next_tick();
            a.write_access = $urandom_range(1);
            a.table_ok = ($urandom_range(9) != 0);
            a.frame = FRAME_BITS'($urandom);
            a.addr = (ADDR_BITS'(pool[$urandom_range(PAGE_POOL - 1)]) << PAGE_SHIFT)
                     | ADDR_BITS'($urandom_range(PAGE_BYTES - 1));
            if ($urandom_range(99) < 85)
            begin
                a.op = OP_LOOKUP;
                send_access(a, r);
                sent++;
                if (!r.hit)
                begin
                    a.op = OP_REFILL;
                    a.tick = next_tick();
                    send_access(a, r);
                    sent++;
                end
            end
            else
            begin
                a.op = $urandom_range(1);
                if ($urandom_range(1))
                    a.addr = $urandom;
                send_access(a, r);
                sent++;
            end
        end
    endtask

    task automatic run_policy_pair(int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        set_policy(POLICY_LRU);
        run_random_words(RANDOM_WORDS);
        set_policy(POLICY_NFU);
        run_random_words(RANDOM_WORDS);
    endtask

    task automatic test_nfu_overrides();
        send_fields(OP_LOOKUP, 0, 32'h0000_0000, 1'b0, 1'b1, 8'h00);
        send_fields(OP_REFILL, 100, 32'h0000_0000, 1'b0, 1'b1, 8'h00);
        send_fields(OP_REFILL, 101, 32'h0000_007F, 1'b0, 1'b0, 8'hFF);
        send_fields(OP_LOOKUP, 5, 32'h0000_0040, 1'b1, 1'b0, 8'h00);
        send_fields(OP_REFILL, 102, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'hA5);
        send_fields(OP_REFILL, 103, 32'h8000_0000, 1'b1, 1'b1, 8'h5A);
        send_fields(OP_LOOKUP, 7, 32'hFFFF_FF80, 1'b0, 1'b1, 8'h00);
        send_fields(OP_LOOKUP, 8, 32'h0000_0100, 1'b1, 1'b1, 8'h00);
        send_fields(OP_REFILL, 0, 32'h1234_5680, 1'b0, 1'b1, 8'h3C);
        send_fields(OP_REFILL, 32'hFFFF_FFFF, 32'h5555_5555, 1'b1, 1'b0, 8'h81);
        send_fields(OP_REFILL, 10201, 32'hAAAA_AAAA, 1'b0, 1'b1, 8'h7E);
        send_fields(OP_REFILL, 10300, 32'h0F0F_0F0F, 1'b0, 1'b1, 8'hC3);
        send_fields(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0F0F_0F00, 1'b1, 1'b1, 8'h00);
    endtask

    task automatic test_lru_order();
        set_policy(POLICY_LRU);
        send_fields(OP_REFILL, 1000, 32'h0000_1000, 1'b0, 1'b1, 8'h11);
        send_fields(OP_REFILL, 1000, 32'h0000_2000, 1'b0, 1'b1, 8'h22);
        send_fields(OP_REFILL, 1000, 32'h0000_3000, 1'b0, 1'b1, 8'h33);
        send_fields(OP_REFILL, 1000, 32'h0000_4000, 1'b0, 1'b1, 8'h44);
        send_fields(OP_LOOKUP, 2000, 32'h0000_1000, 1'b1, 1'b1, 8'h00);
        send_fields(OP_LOOKUP, 2001, 32'h0000_3010, 1'b0, 1'b1, 8'h00);
        send_fields(OP_REFILL, 2002, 32'h0000_5000, 1'b0, 1'b0, 8'h55);
        send_fields(OP_REFILL, 0, 32'h0000_6000, 1'b0, 1'b1, 8'h66);
        send_fields(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_6000, 1'b1, 1'b1, 8'h00);
        send_fields(OP_REFILL, 2003, 32'h0000_7000, 1'b0, 1'b1, 8'h77);
    endtask

    task automatic test_no_idling();
        run_policy_pair(0, 0);
    endtask

    task automatic test_sparse_sender();
        run_policy_pair(86, 0);
    endtask

    task automatic test_slow_receiver();
        run_policy_pair(0, 86);
    endtask

    task automatic test_both_idle();
        run_policy_pair(35, 35);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        hold_requests++;
        run_random_words(40);
        drain_results();
        run_random_words(12);
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        tlb_outcome_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with no access pending, expected none, got hit %0b frame %0h",
                         $time, hit, frame_out);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("hit", want.hit, hit);
                compare_field("frame_out", want.frame, frame_out);
                compare_field("victim_index", want.victim, victim_index);
                compare_field("evicted_valid", want.ev_valid, evicted_valid);
                compare_field("evicted_page", want.ev_page, evicted_page);
                compare_field("evicted_dirty", want.ev_dirty, evicted_dirty);
                compare_field("page_fault", want.fault, page_fault);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            tlb_valid[i] = 1'b0;
            tlb_page[i] = '0;
            tlb_frame[i] = '0;
            tlb_dirty[i] = 1'b0;
            tlb_last_use[i] = '0;
            tlb_refs[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_nfu_overrides();
        test_lru_order();
        test_no_idling();
        test_sparse_sender();
        test_slow_receiver();
        test_both_idle();
        test_backpressure();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d result words: %0d lookups with %0d hits, %0d refills",
                 results_seen, lookups, lookup_hits, refills);
        $display("with %0d page faults and %0d dirty evictions, under both victim policies.",
                 faults, dirty_evictions);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
